// ===== sv/particle_pull_move_color_top_assert.svh =====
// assertion macros for the particle pull, move and color pipeline
`ifndef PARTICLE_PULL_MOVE_COLOR_TOP_ASSERT_SVH
`define PARTICLE_PULL_MOVE_COLOR_TOP_ASSERT_SVH

// same-cycle implication
`define PPMC_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPMC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ppmc_pkg.sv =====
// shared types and constants for the particle pull, move and color pipeline
`default_nettype none

package ppmc_pkg;

	localparam int FRAC_BITS = 8;

	typedef enum logic [1:0] {
		ACT_MOVE    = 2'd0,
		ACT_ATTRACT = 2'd1,
		ACT_REPEL   = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		CFG_FRICTION      = 3'd0,
		CFG_PULL_RADIUS   = 3'd1,
		CFG_PULL_GAIN     = 3'd2,
		CFG_SCREEN_WIDTH  = 3'd3,
		CFG_SCREEN_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} hue_sec_t;

	localparam logic [15:0] FRICTION_RST = 16'd64881;
	localparam logic [11:0] RADIUS_RST   = 12'd400;
	localparam logic [15:0] GAIN_RST     = 16'd256;
	localparam logic [12:0] WIDTH_RST    = 13'd1920;
	localparam logic [12:0] HEIGHT_RST   = 13'd1080;

	// speed above this saturates both value and hue
	localparam logic [14:0] SPEED_SAT = 15'd14592;
	// floor(x/5) = (x * DIV5_MUL) >> 24 for x below 2^22
	localparam logic [21:0] DIV5_MUL  = 22'd3355444;
	localparam logic [15:0] VAL_MAX   = 16'd62259;
	localparam logic [18:0] HUE6_MAX  = 19'd373555;

	typedef struct packed {
		logic               pull;
		logic               sub_x;
		logic               sub_y;
		logic [19:0]        px;
		logic [19:0]        py;
		logic signed [19:0] vx;
		logic signed [19:0] vy;
	} part_t;

	typedef struct packed {
		part_t       part;
		logic [35:0] prod_x;
		logic [35:0] prod_y;
	} dist_pay_t;

	typedef struct packed {
		logic [19:0]        px;
		logic [19:0]        py;
		logic signed [19:0] vx;
		logic signed [19:0] vy;
	} motion_t;

endpackage

`default_nettype wire

// ===== sv/particle_pull_move_color_top.sv =====
// top level of the particle pull, move, bounce and speed color pipeline
//
//   channel  dir  handshake              word
//   s_       in   s_tvalid / s_tready    tuser action, tdata cursor, position, velocity
//   m_       out  m_tvalid / m_tready    tdata new position, velocity, rgb
//   cfg_     in   cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
// one particle per cycle while the output word is not held; 12 plain stages, 21 for the cursor
// distance root, 17 for the pull divide, 20 for the speed root
// every stage moves together; a held output word freezes the whole pipe and
// s_tready drops in the same cycle, nothing is dropped or repeated
// arst_n clears the valid bits and loads the register reset values
// cfg_ready is always high
`default_nettype none

`include "particle_pull_move_color_top_assert.svh"

module particle_pull_move_color_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser,   // action
	input  logic [103:0] s_tdata,   // cursor_x, cursor_y, pos_x, pos_y, vel_x, vel_y
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y, red, green, blue
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	import ppmc_pkg::*;

	// ---------------- configuration ----------------
	logic [15:0] friction_q;
	logic [11:0] radius_q;
	logic [15:0] gain_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [39:0] rr2_q;
	logic [20:0] lim_x_q;
	logic [20:0] lim_y_q;
	logic [19:0] hi_x_q;
	logic [19:0] hi_y_q;

	logic [23:0] r2;
	logic [12:0] sz_x;
	logic [12:0] sz_y;
	logic [20:0] top_x;
	logic [20:0] top_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction_q <= FRICTION_RST;
			radius_q   <= RADIUS_RST;
			gain_q     <= GAIN_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRICTION:      friction_q <= cfg_data;
				CFG_PULL_RADIUS:   radius_q   <= cfg_data[11:0];
				CFG_PULL_GAIN:     gain_q     <= cfg_data;
				CFG_SCREEN_WIDTH:  width_q    <= cfg_data[12:0];
				CFG_SCREEN_HEIGHT: height_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// derived bounds; a zero screen size counts as one pixel
	assign r2    = radius_q * radius_q;
	assign sz_x  = (width_q == 13'd0) ? 13'd1 : width_q;
	assign sz_y  = (height_q == 13'd0) ? 13'd1 : height_q;
	assign top_x = {sz_x - 13'd1, {FRAC_BITS{1'b0}}};
	assign top_y = {sz_y - 13'd1, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		rr2_q   <= {r2, {(2 * FRAC_BITS){1'b0}}};
		lim_x_q <= {sz_x, {FRAC_BITS{1'b0}}};
		lim_y_q <= {sz_y, {FRAC_BITS{1'b0}}};
		hi_x_q  <= (top_x > 21'hFFFFF) ? 20'hFFFFF : top_x[19:0];
		hi_y_q  <= (top_y > 21'hFFFFF) ? 20'hFFFFF : top_y[19:0];
	end

	// whole pipe advances unless the output word is held
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- s1: input word ----------------
	logic               vld_s1;
	logic [1:0]         act_s1;
	logic [11:0]        cx_s1;
	logic [11:0]        cy_s1;
	logic [19:0]        px_s1;
	logic [19:0]        py_s1;
	logic signed [19:0] vx_s1;
	logic signed [19:0] vy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= s_tuser;
			cx_s1  <= s_tdata[11:0];
			cy_s1  <= s_tdata[23:12];
			px_s1  <= s_tdata[43:24];
			py_s1  <= s_tdata[63:44];
			vx_s1  <= s_tdata[83:64];
			vy_s1  <= s_tdata[103:84];
		end
	end

	// ---------------- s2: offsets, squares, gain products ----------------
	logic signed [20:0] dx;
	logic signed [20:0] dy;
	logic [19:0]        mag_dx;
	logic [19:0]        mag_dy;
	logic [39:0]        sq_dx;
	logic [39:0]        sq_dy;
	logic [35:0]        gp_x;
	logic [35:0]        gp_y;
	logic               is_pull;
	logic               attract;

	assign dx      = $signed({1'b0, px_s1}) - $signed({1'b0, cx_s1, {FRAC_BITS{1'b0}}});
	assign dy      = $signed({1'b0, py_s1}) - $signed({1'b0, cy_s1, {FRAC_BITS{1'b0}}});
	assign mag_dx  = dx[20] ? 20'(-dx) : dx[19:0];
	assign mag_dy  = dy[20] ? 20'(-dy) : dy[19:0];
	assign sq_dx   = mag_dx * mag_dx;
	assign sq_dy   = mag_dy * mag_dy;
	assign gp_x    = mag_dx * gain_q;
	assign gp_y    = mag_dy * gain_q;
	assign is_pull = (act_s1 == ACT_ATTRACT) || (act_s1 == ACT_REPEL);
	assign attract = (act_s1 == ACT_ATTRACT);

	logic        vld_s2;
	logic [39:0] sqx_s2;
	logic [39:0] sqy_s2;
	dist_pay_t   pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2            <= sq_dx;
			sqy_s2            <= sq_dy;
			pay_s2.prod_x     <= gp_x;
			pay_s2.prod_y     <= gp_y;
			pay_s2.part.pull  <= is_pull;
			// subtract when attracting along a positive offset or repelling along a negative one
			pay_s2.part.sub_x <= attract ^ dx[20];
			pay_s2.part.sub_y <= attract ^ dy[20];
			pay_s2.part.px    <= px_s1;
			pay_s2.part.py    <= py_s1;
			pay_s2.part.vx    <= vx_s1;
			pay_s2.part.vy    <= vy_s1;
		end
	end

	// ---------------- s3: squared distance and radius test ----------------
	logic [40:0] d2;
	logic        in_rad;
	dist_pay_t   pay_d2;

	assign d2     = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign in_rad = (d2 != 41'd0) && (d2 <= {1'b0, rr2_q});

	always_comb begin
		pay_d2           = pay_s2;
		pay_d2.part.pull = pay_s2.part.pull && in_rad;
	end

	logic        vld_s3;
	logic [40:0] d2_s3;
	dist_pay_t   pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3  <= d2;
			pay_s3 <= pay_d2;
		end
	end

	// ---------------- distance root ----------------
	logic        dist_vld;
	logic [20:0] dist_root;
	dist_pay_t   dist_pay;

	ppmc_sqrt #(
		.N  (42),
		.PW ($bits(dist_pay_t))
	) u_dist_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_rad    ({1'b0, d2_s3}),
		.in_pay    (pay_s3),
		.out_valid (dist_vld),
		.out_root  (dist_root),
		.out_pay   (dist_pay)
	);

	// ---------------- pull quotients ----------------
	logic        quo_vld;
	logic [16:0] quo_x;
	logic [16:0] quo_y;
	part_t       quo_part;

	ppmc_div #(
		.DW (36),
		.VW (21),
		.QB (17),
		.PW ($bits(part_t))
	) u_pull_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dist_vld),
		.in_num_a  (dist_pay.prod_x),
		.in_num_b  (dist_pay.prod_y),
		.in_den    (dist_root),
		.in_pay    (dist_pay.part),
		.out_valid (quo_vld),
		.out_quo_a (quo_x),
		.out_quo_b (quo_y),
		.out_pay   (quo_part)
	);

	// ---------------- s4: apply pull with saturation ----------------
	function automatic logic signed [19:0] pull_vel(
		input logic signed [19:0] v,
		input logic [16:0]        q,
		input logic               sub
	);
		logic signed [21:0] w;
		w = sub ? ($signed({{2{v[19]}}, v}) - $signed({5'b0, q}))
		        : ($signed({{2{v[19]}}, v}) + $signed({5'b0, q}));
		if (w > 22'sd524287) begin
			return 20'sd524287;
		end else if (w < -22'sd524288) begin
			return -20'sd524288;
		end else begin
			return w[19:0];
		end
	endfunction

	logic    vld_s4;
	motion_t mv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= quo_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s4.px <= quo_part.px;
			mv_s4.py <= quo_part.py;
			mv_s4.vx <= quo_part.pull ? pull_vel(quo_part.vx, quo_x, quo_part.sub_x)
			                          : quo_part.vx;
			mv_s4.vy <= quo_part.pull ? pull_vel(quo_part.vy, quo_y, quo_part.sub_y)
			                          : quo_part.vy;
		end
	end

	// ---------------- s5: half step and bounce test ----------------
	logic signed [19:0] half_x;
	logic signed [19:0] half_y;
	logic signed [21:0] np_x;
	logic signed [21:0] np_y;
	logic               flip_x;
	logic               flip_y;
	logic [19:0]        vm_x;
	logic [19:0]        vm_y;

	assign half_x = $signed(mv_s4.vx) >>> 1;
	assign half_y = $signed(mv_s4.vy) >>> 1;
	assign np_x   = $signed({2'b0, mv_s4.px}) + $signed({{2{half_x[19]}}, half_x});
	assign np_y   = $signed({2'b0, mv_s4.py}) + $signed({{2{half_y[19]}}, half_y});
	assign flip_x = np_x[21] || (np_x[20:0] >= lim_x_q);
	assign flip_y = np_y[21] || (np_y[20:0] >= lim_y_q);
	// magnitude of the most negative velocity still fits unsigned
	assign vm_x   = mv_s4.vx[19] ? 20'(-mv_s4.vx) : mv_s4.vx;
	assign vm_y   = mv_s4.vy[19] ? 20'(-mv_s4.vy) : mv_s4.vy;

	logic        vld_s5;
	logic [21:0] p_x_s5;
	logic [21:0] p_y_s5;
	logic [19:0] vm_x_s5;
	logic [19:0] vm_y_s5;
	logic        neg_x_s5;
	logic        neg_y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_x_s5   <= np_x;
			p_y_s5   <= np_y;
			vm_x_s5  <= vm_x;
			vm_y_s5  <= vm_y;
			neg_x_s5 <= mv_s4.vx[19] ^ flip_x;
			neg_y_s5 <= mv_s4.vy[19] ^ flip_y;
		end
	end

	// ---------------- s6: friction product and clamp ----------------
	logic        vld_s6;
	logic [35:0] fp_x_s6;
	logic [35:0] fp_y_s6;
	logic [19:0] pos_x_s6;
	logic [19:0] pos_y_s6;
	logic        neg_x_s6;
	logic        neg_y_s6;
	logic [35:0] fp_x;
	logic [35:0] fp_y;
	logic [19:0] cp_x;
	logic [19:0] cp_y;

	assign fp_x = vm_x_s5 * friction_q;
	assign fp_y = vm_y_s5 * friction_q;
	assign cp_x = p_x_s5[21] ? 20'd0 :
	              (p_x_s5[20:0] > {1'b0, hi_x_q}) ? hi_x_q : p_x_s5[19:0];
	assign cp_y = p_y_s5[21] ? 20'd0 :
	              (p_y_s5[20:0] > {1'b0, hi_y_q}) ? hi_y_q : p_y_s5[19:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fp_x_s6  <= fp_x;
			fp_y_s6  <= fp_y;
			pos_x_s6 <= cp_x;
			pos_y_s6 <= cp_y;
			neg_x_s6 <= neg_x_s5;
			neg_y_s6 <= neg_y_s5;
		end
	end

	// ---------------- s7: final velocity and speed squares ----------------
	logic [19:0] fm_x;
	logic [19:0] fm_y;
	logic [37:0] ssq_x;
	logic [37:0] ssq_y;

	// scaled magnitude stays below 2^19, no saturation needed
	assign fm_x  = fp_x_s6[35:16];
	assign fm_y  = fp_y_s6[35:16];
	assign ssq_x = fm_x[18:0] * fm_x[18:0];
	assign ssq_y = fm_y[18:0] * fm_y[18:0];

	logic        vld_s7;
	motion_t     mv_s7;
	logic [37:0] sq_x_s7;
	logic [37:0] sq_y_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s7.px <= pos_x_s6;
			mv_s7.py <= pos_y_s6;
			mv_s7.vx <= neg_x_s6 ? 20'(-fm_x) : fm_x;
			mv_s7.vy <= neg_y_s6 ? 20'(-fm_y) : fm_y;
			sq_x_s7  <= ssq_x;
			sq_y_s7  <= ssq_y;
		end
	end

	// ---------------- s8: speed squared ----------------
	logic        vld_s8;
	motion_t     mv_s8;
	logic [38:0] sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s8  <= mv_s7;
			sum_s8 <= {1'b0, sq_x_s7} + {1'b0, sq_y_s7};
		end
	end

	// ---------------- speed root ----------------
	logic        spd_vld;
	logic [19:0] speed;
	motion_t     spd_mv;

	ppmc_sqrt #(
		.N  (40),
		.PW ($bits(motion_t))
	) u_speed_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s8),
		.in_rad    ({1'b0, sum_s8}),
		.in_pay    (mv_s8),
		.out_valid (spd_vld),
		.out_root  (speed),
		.out_pay   (spd_mv)
	);

	// ---------------- s9: speed * 256 / 5 by reciprocal ----------------
	logic [14:0] spd_c;

	assign spd_c = (speed > 20'(SPEED_SAT)) ? SPEED_SAT : speed[14:0];

	logic        vld_s9;
	motion_t     mv_s9;
	logic [44:0] q5p_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= spd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s9  <= spd_mv;
			q5p_s9 <= {spd_c, 8'b0} * DIV5_MUL;
		end
	end

	// ---------------- s10: value and six-times hue ----------------
	logic [20:0] q5;
	logic [19:0] h6w;

	assign q5  = q5p_s9[44:24];
	assign h6w = q5[20:1];

	logic        vld_s10;
	motion_t     mv_s10;
	logic [15:0] val_s10;
	logic [18:0] h6_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s10  <= mv_s9;
			val_s10 <= (q5 > 21'(VAL_MAX)) ? VAL_MAX : q5[15:0];
			h6_s10  <= (h6w > 20'(HUE6_MAX)) ? HUE6_MAX : h6w[18:0];
		end
	end

	// ---------------- s11: falling and rising ramps ----------------
	logic [15:0] hf;
	logic [32:0] qprod;
	logic [31:0] tprod;

	assign hf    = h6_s10[15:0];
	assign qprod = val_s10 * (17'h10000 - {1'b0, hf});
	assign tprod = val_s10 * hf;

	logic        vld_s11;
	motion_t     mv_s11;
	logic [15:0] val_s11;
	logic [15:0] qv_s11;
	logic [15:0] tv_s11;
	logic [2:0]  sec_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s11  <= mv_s10;
			val_s11 <= val_s10;
			qv_s11  <= qprod[31:16];
			tv_s11  <= tprod[31:16];
			sec_s11 <= h6_s10[18:16];
		end
	end

	// ---------------- s12: channel select, 8-bit scale, output word ----------------
	function automatic logic [7:0] to8(input logic [15:0] x);
		logic [24:0] w;
		w = {1'b0, x, 8'b0} - {9'b0, x} + 25'd32768;
		return w[23:16];
	endfunction

	logic [15:0] ch_r;
	logic [15:0] ch_g;
	logic [15:0] ch_b;

	always_comb begin
		case (hue_sec_t'(sec_s11))
			SEC_R_TO_Y: begin ch_r = val_s11; ch_g = tv_s11;  ch_b = 16'd0;   end
			SEC_Y_TO_G: begin ch_r = qv_s11;  ch_g = val_s11; ch_b = 16'd0;   end
			SEC_G_TO_C: begin ch_r = 16'd0;   ch_g = val_s11; ch_b = tv_s11;  end
			SEC_C_TO_B: begin ch_r = 16'd0;   ch_g = qv_s11;  ch_b = val_s11; end
			SEC_B_TO_M: begin ch_r = tv_s11;  ch_g = 16'd0;   ch_b = val_s11; end
			default:    begin ch_r = val_s11; ch_g = 16'd0;   ch_b = qv_s11;  end
		endcase
	end

	logic        vld_s12;
	motion_t     mv_s12;
	logic [7:0]  red_s12;
	logic [7:0]  green_s12;
	logic [7:0]  blue_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s12    <= mv_s11;
			red_s12   <= to8(ch_r);
			green_s12 <= to8(ch_g);
			blue_s12  <= to8(ch_b);
		end
	end

	assign m_tvalid = vld_s12;
	assign m_tdata  = {blue_s12, green_s12, red_s12,
	                   mv_s12.vy, mv_s12.vx, mv_s12.py, mv_s12.px};

	// ---------------- checks ----------------
	`PPMC_ASSERT_IMPLY(a_pos_x_on_screen, clk, arst_n, m_tvalid, mv_s12.px <= hi_x_q, "x position beyond screen clamp")
	`PPMC_ASSERT_IMPLY(a_pos_y_on_screen, clk, arst_n, m_tvalid, mv_s12.py <= hi_y_q, "y position beyond screen clamp")
	`PPMC_ASSERT_IMPLY(a_one_channel_dark, clk, arst_n, m_tvalid, red_s12 == 8'd0 || green_s12 == 8'd0 || blue_s12 == 8'd0, "no color channel is zero")
	`PPMC_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, vld_s1, "accepted word missing from first stage")

endmodule

`default_nettype wire

// ===== sv/ppmc_sqrt.sv =====
// pipelined integer square root, one result bit per stage, with sideband
`default_nettype none

module ppmc_sqrt #(
	parameter int N  = 42,
	parameter int PW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [N-1:0]   in_rad,
	input  logic [PW-1:0]  in_pay,
	output logic           out_valid,
	output logic [N/2-1:0] out_root,
	output logic [PW-1:0]  out_pay
);

	localparam int R  = N / 2;
	localparam int RW = R + 3;

	logic          vld_s  [R];
	logic [N-1:0]  rad_s  [R];
	logic [RW-1:0] rem_s  [R];
	logic [R-1:0]  root_s [R];
	logic [PW-1:0] pay_s  [R];

	for (genvar k = 0; k < R; k++) begin : g_stg
		logic          vld_i;
		logic [N-1:0]  rad_i;
		logic [RW-1:0] rem_i;
		logic [R-1:0]  root_i;
		logic [PW-1:0] pay_i;
		logic [RW-1:0] cur;
		logic [RW-1:0] tst;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rad_i  = in_rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign pay_i  = in_pay;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign pay_i  = pay_s[k-1];
		end

		// bring down the next two radicand bits, trial subtract 4r+1
		assign cur = {rem_i[RW-3:0], rad_i[N-1 -: 2]};
		assign tst = RW'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_i << 2;
				pay_s[k] <= pay_i;
				if (cur >= tst) begin
					rem_s[k]  <= cur - tst;
					root_s[k] <= {root_i[R-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {root_i[R-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[R-1];
	assign out_root  = root_s[R-1];
	assign out_pay   = pay_s[R-1];

endmodule

`default_nettype wire

// ===== sv/ppmc_div.sv =====
// pipelined restoring divider, two dividends over one divisor, one quotient bit per stage
`default_nettype none

module ppmc_div #(
	parameter int DW = 36,
	parameter int VW = 21,
	parameter int QB = 17,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_num_a,
	input  logic [DW-1:0] in_num_b,
	input  logic [VW-1:0] in_den,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QB-1:0] out_quo_a,
	output logic [QB-1:0] out_quo_b,
	output logic [PW-1:0] out_pay
);

	localparam int CW = (DW > VW + QB) ? DW : VW + QB;

	logic          vld_s   [QB];
	logic [DW-1:0] rem_a_s [QB];
	logic [DW-1:0] rem_b_s [QB];
	logic [QB-1:0] quo_a_s [QB];
	logic [QB-1:0] quo_b_s [QB];
	logic [VW-1:0] den_s   [QB];
	logic [PW-1:0] pay_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stg
		logic          vld_i;
		logic [DW-1:0] rem_a_i;
		logic [DW-1:0] rem_b_i;
		logic [QB-1:0] quo_a_i;
		logic [QB-1:0] quo_b_i;
		logic [VW-1:0] den_i;
		logic [PW-1:0] pay_i;
		logic [CW-1:0] sh;
		logic [CW-1:0] wa;
		logic [CW-1:0] wb;

		if (k == 0) begin : g_first
			assign vld_i   = in_valid;
			assign rem_a_i = in_num_a;
			assign rem_b_i = in_num_b;
			assign quo_a_i = '0;
			assign quo_b_i = '0;
			assign den_i   = in_den;
			assign pay_i   = in_pay;
		end else begin : g_next
			assign vld_i   = vld_s[k-1];
			assign rem_a_i = rem_a_s[k-1];
			assign rem_b_i = rem_b_s[k-1];
			assign quo_a_i = quo_a_s[k-1];
			assign quo_b_i = quo_b_s[k-1];
			assign den_i   = den_s[k-1];
			assign pay_i   = pay_s[k-1];
		end

		// divisor aligned to this stage's quotient bit
		assign sh = CW'(den_i) << (QB - 1 - k);
		assign wa = CW'(rem_a_i);
		assign wb = CW'(rem_b_i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_i;
				pay_s[k] <= pay_i;
				if (wa >= sh) begin
					rem_a_s[k] <= DW'(wa - sh);
					quo_a_s[k] <= {quo_a_i[QB-2:0], 1'b1};
				end else begin
					rem_a_s[k] <= rem_a_i;
					quo_a_s[k] <= {quo_a_i[QB-2:0], 1'b0};
				end
				if (wb >= sh) begin
					rem_b_s[k] <= DW'(wb - sh);
					quo_b_s[k] <= {quo_b_i[QB-2:0], 1'b1};
				end else begin
					rem_b_s[k] <= rem_b_i;
					quo_b_s[k] <= {quo_b_i[QB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_quo_a = quo_a_s[QB-1];
	assign out_quo_b = quo_b_s[QB-1];
	assign out_pay   = pay_s[QB-1];

endmodule

`default_nettype wire

// ===== tb/sv/particle_pull_move_color_top_tb.sv =====
// testbench for the particle pull, move and color pipeline with a self-checking scoreboard
`default_nettype none

module particle_pull_move_color_top_tb;
	import ppmc_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 90;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]         action;
		logic [11:0]        cx;
		logic [11:0]        cy;
		logic [19:0]        px;
		logic [19:0]        py;
		logic signed [19:0] vx;
		logic signed [19:0] vy;
	} particle_in_t;

	typedef struct {
		logic [19:0] px;
		logic [19:0] py;
		logic [19:0] vx;
		logic [19:0] vy;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} step_out_t;

	class step_scoreboard;
		longint unsigned fric, radius, gain, width, height;
		step_out_t expected_steps[$];
		int errors;

		function new();
			fric = FRICTION_RST;
			radius = RADIUS_RST;
			gain = GAIN_RST;
			width = WIDTH_RST;
			height = HEIGHT_RST;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] val);
			case (idx)
				CFG_FRICTION: fric = val;
				CFG_PULL_RADIUS: radius = val[11:0];
				CFG_PULL_GAIN: gain = val;
				CFG_SCREEN_WIDTH: width = val[12:0];
				CFG_SCREEN_HEIGHT: height = val[12:0];
				default: ;
			endcase
		endfunction

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function longint unsigned magn(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint sat20(longint v);
			if (v > 524287) return 524287;
			if (v < -524288) return -524288;
			return v;
		endfunction

		function longint pull_of(longint off, longint unsigned d);
			longint q;
			q = ((magn(off) * gain) << FRAC_BITS) / (d << 8);
			return off < 0 ? -q : q;
		endfunction

		// bounce, friction and clamp for one axis
		function longint move_axis(longint pos, inout longint vel, input longint unsigned size);
			longint lim, hi, p, m;
			if (size == 0) size = 1;
			lim = size << FRAC_BITS;
			p = pos + (vel >= 0 ? vel / 2 : -((magn(vel) + 1) / 2));
			if (p < 0 || p >= lim) vel = -vel;
			m = (magn(vel) * fric) >> 16;
			vel = sat20(vel < 0 ? -m : m);
			hi = (size - 1) << FRAC_BITS;
			if (hi > 20'hFFFFF) hi = 20'hFFFFF;
			if (p < 0) p = 0;
			if (p > hi) p = hi;
			return p;
		endfunction

		function logic [7:0] to8(longint unsigned x);
			return 8'((x * 255 + 32768) >> 16);
		endfunction

		function void note(particle_in_t it);
			longint px, py, vx, vy, dx, dy, ax, ay;
			longint unsigned d2, rr, d, speed, v, h6, f, q, t, r, g, b;
			step_out_t res;
			px = it.px;
			py = it.py;
			vx = it.vx;
			vy = it.vy;
			if (it.action == ACT_ATTRACT || it.action == ACT_REPEL) begin
				dx = px - (longint'(it.cx) << FRAC_BITS);
				dy = py - (longint'(it.cy) << FRAC_BITS);
				d2 = magn(dx) * magn(dx) + magn(dy) * magn(dy);
				rr = radius << FRAC_BITS;
				// cursor on the particle adds nothing
				if (d2 != 0 && d2 <= rr * rr) begin
					d = isqrt(d2);
					ax = pull_of(dx, d);
					ay = pull_of(dy, d);
					if (it.action == ACT_ATTRACT) begin
						vx = vx - ax;
						vy = vy - ay;
					end else begin
						vx = vx + ax;
						vy = vy + ay;
					end
					vx = sat20(vx);
					vy = sat20(vy);
				end
			end
			px = move_axis(px, vx, width);
			py = move_axis(py, vy, height);
			speed = isqrt(magn(vx) * magn(vx) + magn(vy) * magn(vy));
			v = (speed * 65536) / (64'd5 << FRAC_BITS);
			if (v > VAL_MAX) v = VAL_MAX;
			h6 = (speed * 65536) / (64'd10 << FRAC_BITS);
			if (h6 > HUE6_MAX) h6 = HUE6_MAX;
			f = h6 & 16'hFFFF;
			q = (v * (65536 - f)) >> 16;
			t = (v * f) >> 16;
			case (3'(h6 >> 16))
				SEC_R_TO_Y: begin r = v; g = t; b = 0; end
				SEC_Y_TO_G: begin r = q; g = v; b = 0; end
				SEC_G_TO_C: begin r = 0; g = v; b = t; end
				SEC_C_TO_B: begin r = 0; g = q; b = v; end
				SEC_B_TO_M: begin r = t; g = 0; b = v; end
				default: begin r = v; g = 0; b = q; end
			endcase
			res.px = 20'(px);
			res.py = 20'(py);
			res.vx = 20'(vx);
			res.vy = 20'(vy);
			res.red = to8(r);
			res.green = to8(g);
			res.blue = to8(b);
			expected_steps = {expected_steps, res};
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check(logic [103:0] w);
			step_out_t e;
			if (expected_steps.size() == 0) begin
				report("unexpected word", w[63:0], 0);
				return;
			end
			e = expected_steps.pop_front();
			if (w[19:0] !== e.px) report("new_pos_x", w[19:0], e.px);
			if (w[39:20] !== e.py) report("new_pos_y", w[39:20], e.py);
			if (w[59:40] !== e.vx) report("new_vel_x", w[59:40], e.vx);
			if (w[79:60] !== e.vy) report("new_vel_y", w[79:60], e.vy);
			if (w[87:80] !== e.red) report("red", w[87:80], e.red);
			if (w[95:88] !== e.green) report("green", w[95:88], e.green);
			if (w[103:96] !== e.blue) report("blue", w[103:96], e.blue);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [1:0] s_tuser = '0;
	logic [103:0] s_tdata = '0;  // cursor_x, cursor_y, pos_x, pos_y, vel_x, vel_y
	logic m_tvalid;
	logic m_tready = 0;
	logic [103:0] m_tdata;       // new_pos_x, new_pos_y, new_vel_x, new_vel_y, red, green, blue
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	step_scoreboard sb = new();
	int phase_no = 0;
	bit hold_done = 0;
	int cyc = 0;
	int idle_cycles = 0;

	particle_pull_move_color_top uut (.*);

	always #1 clk = ~clk;

	// receiver: stall pattern steps through four modes in turn, one long hold-off in phase 3
	always @(posedge clk) begin
		logic ok;
		cyc <= cyc + 1;
		if (m_tvalid && m_tready) sb.check(m_tdata);
		case ((cyc / 256) % 4)
			0: ok = 1;
			1: ok = $urandom_range(0, 1);
			2: ok = ($urandom_range(0, 3) == 0);
			default: ok = (cyc % 7) < 3;
		endcase
		m_tready <= ok && !(phase_no == 3 && !hold_done);
	end

	initial begin
		wait (phase_no == 3);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_done = 1;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// leaves cfg_valid high, caller lowers it after the last word
	task write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task write_all(logic [15:0] fr, logic [15:0] rad, logic [15:0] gn,
			logic [15:0] w, logic [15:0] h);
		write_reg(CFG_FRICTION, fr);
		write_reg(CFG_PULL_RADIUS, rad);
		write_reg(CFG_PULL_GAIN, gn);
		write_reg(CFG_SCREEN_WIDTH, w);
		write_reg(CFG_SCREEN_HEIGHT, h);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// leaves s_tvalid high so back-to-back words need no gap
	task send_item(particle_in_t it);
		s_tvalid <= 1;
		s_tuser <= it.action;
		s_tdata <= {it.vy, it.vx, it.py, it.px, it.cy, it.cx};
		do @(posedge clk); while (!s_tready);
		sb.note(it);
	endtask

	task drain();
		s_tvalid <= 0;
		while (sb.expected_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function particle_in_t mk(logic [1:0] a, logic [11:0] cx, logic [11:0] cy,
			logic [19:0] px, logic [19:0] py, logic signed [19:0] vx, logic signed [19:0] vy);
		particle_in_t it;
		it.action = a; it.cx = cx; it.cy = cy;
		it.px = px; it.py = py; it.vx = vx; it.vy = vy;
		return it;
	endfunction

	function particle_in_t rand_item();
		particle_in_t it;
		longint unsigned w, h, lim;
		int off;
		it.action = 2'($urandom_range(0, 3));
		it.cx = 12'($urandom);
		it.cy = 12'($urandom);
		it.px = 20'($urandom);
		it.py = 20'($urandom);
		it.vx = 20'($urandom);
		it.vy = 20'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			// particle on screen, cursor close by, moderate speed
			if ($urandom_range(0, 3) != 0) it.action = 2'($urandom_range(1, 2));
			w = sb.width == 0 ? 1 : sb.width;
			h = sb.height == 0 ? 1 : sb.height;
			lim = (w << FRAC_BITS) - 1;
			it.px = 20'($urandom_range(0, 32'(lim > 20'hFFFFF ? 20'hFFFFF : lim)));
			lim = (h << FRAC_BITS) - 1;
			it.py = 20'($urandom_range(0, 32'(lim > 20'hFFFFF ? 20'hFFFFF : lim)));
			off = int'($urandom_range(0, 32'(2 * sb.radius + 2))) - int'(sb.radius) - 1;
			it.cx = 12'((it.px >> FRAC_BITS) + off);
			off = int'($urandom_range(0, 32'(2 * sb.radius + 2))) - int'(sb.radius) - 1;
			it.cy = 12'((it.py >> FRAC_BITS) + off);
			if ($urandom_range(0, 3) != 0) begin
				it.vx = 20'(int'($urandom_range(0, 32767)) - 16384);
				it.vy = 20'(int'($urandom_range(0, 32767)) - 16384);
			end
		end
		return it;
	endfunction

	task directed();
		send_item(mk(ACT_MOVE, 0, 0, 0, 0, 0, 0));
		send_item(mk(ACT_MOVE, 12'hFFF, 12'hFFF, 20'hFFFFF, 20'hFFFFF, 20'sh7FFFF, 20'sh7FFFF));
		send_item(mk(ACT_MOVE, 0, 0, 0, 0, -20'sh80000, -20'sh80000));
		send_item(mk(ACT_MOVE, 0, 0, 20'hFFFFF, 0, 20'sh7FFFF, -20'sh80000));
		send_item(mk(ACT_SPARE, 100, 100, 20'd25600, 20'd25600, 20'sd300, -20'sd300));
		// cursor exactly on the particle
		send_item(mk(ACT_ATTRACT, 100, 50, 20'd25600, 20'd12800, 20'sd10, 20'sd10));
		send_item(mk(ACT_REPEL, 100, 50, 20'd25600, 20'd12800, 20'sd10, 20'sd10));
		send_item(mk(ACT_ATTRACT, 100, 50, 20'd25700, 20'd12800, 0, 0));
		send_item(mk(ACT_REPEL, 100, 50, 20'd25600, 20'd12700, 0, 0));
		send_item(mk(ACT_ATTRACT, 0, 0, 20'd1, 20'd1, 20'sh7FFFF, -20'sh80000));
		send_item(mk(ACT_REPEL, 12'hFFF, 12'hFFF, 20'hFFFFF, 20'hFFFFE, -20'sh80000, 20'sh7FFFF));
		send_item(mk(ACT_ATTRACT, 500, 300, 20'd120000, 20'd70000, 20'sd5000, -20'sd7000));
		send_item(mk(ACT_REPEL, 500, 300, 20'd130000, 20'd80000, -20'sd3000, 20'sd1));
		send_item(mk(ACT_MOVE, 0, 0, 20'd100, 20'd100, -20'sd1000, 20'sd1000));
		send_item(mk(ACT_MOVE, 0, 0, 20'd2000, 20'd2000, 20'sd14592, 20'sd0));
		send_item(mk(ACT_MOVE, 0, 0, 20'd2000, 20'd2000, 20'sd3000, 20'sd1500));
		send_item(mk(ACT_MOVE, 0, 0, 20'd2000, 20'd2000, -20'sd6000, 20'sd6000));
		send_item(mk(ACT_MOVE, 0, 0, 20'd2000, 20'd2000, -20'sd1, -20'sd1));
	endtask

	task random_part(int n);
		int burst;
		burst = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			send_item(rand_item());
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) begin
					s_tvalid <= 0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		random_part(86);
		drain();
		phase_no <= 1;
		// zero screen size, widest radius, strongest pull
		write_all(16'd0, 16'd4095, 16'hFFFF, 16'd0, 16'd0);
		directed();
		random_part(50);
		drain();
		phase_no <= 2;
		// oversized screen, all-bits-set values, widest radius and no pull
		write_all(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd4096);
		directed();
		random_part(50);
		drain();
		phase_no <= 3;
		write_all(16'd32768, 16'd100, 16'd1000, 16'd640, 16'd480);
		random_part(80);
		drain();
		phase_no <= 4;
		write_all(FRICTION_RST, RADIUS_RST, GAIN_RST, WIDTH_RST, HEIGHT_RST);
		random_part(60);
		drain();
		phase_no <= 5;
		write_all(16'd60000, 16'd2000, 16'd12000, 16'd4096, 16'd1);
		random_part(70);
		drain();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
